// ----- design/staggered_grid_trilinear_sampler_defines.svh -----
// Assertion macros shared by the staggered grid sampler RTL
`ifndef STAGGERED_GRID_TRILINEAR_SAMPLER_DEFINES_SVH
`define STAGGERED_GRID_TRILINEAR_SAMPLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SGTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sgts_pkg.sv -----
// Types, constants and helper functions of the staggered grid sampler
`timescale 1ns / 1ps

package sgts_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_CELLS  = 32;
  localparam int FACE_DEPTH = (MAX_CELLS + 1) * MAX_CELLS * MAX_CELLS;
  localparam int CELL_DEPTH = MAX_CELLS * MAX_CELLS * MAX_CELLS;
  localparam int ADDR_W     = $clog2(FACE_DEPTH);
  localparam int CELL_AW    = $clog2(CELL_DEPTH);

  localparam logic       REQ_WRITE  = 1'b0;
  localparam logic       REQ_SAMPLE = 1'b1;

  localparam logic [2:0] COMP_U      = 3'd0;
  localparam logic [2:0] COMP_SCALAR = 3'd3;
  localparam logic [2:0] COMP_VEL    = 3'd4;

  localparam logic [1:0] STORE_U      = 2'd0;
  localparam logic [1:0] STORE_V      = 2'd1;
  localparam logic [1:0] STORE_W      = 2'd2;
  localparam logic [1:0] STORE_SCALAR = 2'd3;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_INV_CELL = 3'd3;
  localparam logic [2:0] CFG_CELLS_X  = 3'd4;
  localparam logic [2:0] CFG_CELLS_Y  = 3'd5;
  localparam logic [2:0] CFG_CELLS_Z  = 3'd6;

  typedef struct packed {
    logic              we;
    logic [1:0]        sel;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } sgts_wr_t;

  typedef struct packed {
    logic              re;
    logic [1:0]        sel;
    logic [ADDR_W-1:0] addr;
  } sgts_rd_t;

  function automatic logic [5:0] eff_cells(input logic [5:0] c);
    logic [5:0] r;
    r = c;
    if (c == 6'd0) r = 6'd1;
    else if (c > 6'(MAX_CELLS)) r = 6'(MAX_CELLS);
    return r;
  endfunction

  // flat entry address: rows of 32 (33 for U), the face axis of a face store holds 33
  function automatic logic [ADDR_W-1:0] grid_addr(input logic [1:0] s, input logic [5:0] i,
                                                  input logic [5:0] j, input logic [5:0] k);
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] a;
    row = ADDR_W'({k[4:0], j[4:0]});
    unique case (s)
      STORE_U: a = (row << 5) + row + ADDR_W'(i);
      STORE_V: a = (((ADDR_W'(k[4:0]) << 5) + ADDR_W'(k[4:0]) + ADDR_W'(j)) << 5)
                   + ADDR_W'(i[4:0]);
      default: a = {k[5:0], j[4:0], i[4:0]};
    endcase
    return a;
  endfunction

endpackage

// ----- design/sgts_grid_mem.sv -----
// Four grid stores with one write port and one registered read port
`timescale 1ns / 1ps

module sgts_grid_mem (
  input  logic               clk,
  input  sgts_pkg::sgts_wr_t wr,
  input  sgts_pkg::sgts_rd_t rd,
  output logic [31:0]        rd_data
);
  import sgts_pkg::*;

  logic [31:0] u_mem [FACE_DEPTH];
  logic [31:0] v_mem [FACE_DEPTH];
  logic [31:0] w_mem [FACE_DEPTH];
  logic [31:0] s_mem [CELL_DEPTH];
  logic [31:0] u_q, v_q, w_q, s_q;
  logic [1:0]  sel_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      unique case (wr.sel)
        STORE_U: u_mem[wr.addr] <= wr.data;
        STORE_V: v_mem[wr.addr] <= wr.data;
        STORE_W: w_mem[wr.addr] <= wr.data;
        default: s_mem[wr.addr[CELL_AW-1:0]] <= wr.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      sel_r <= rd.sel;
      unique case (rd.sel)
        STORE_U: u_q <= u_mem[rd.addr];
        STORE_V: v_q <= v_mem[rd.addr];
        STORE_W: w_q <= w_mem[rd.addr];
        default: s_q <= s_mem[rd.addr[CELL_AW-1:0]];
      endcase
    end
  end

  always_comb begin
    unique case (sel_r)
      STORE_U: rd_data = u_q;
      STORE_V: rd_data = v_q;
      STORE_W: rd_data = w_q;
      default: rd_data = s_q;
    endcase
  end

endmodule

// ----- design/staggered_grid_trilinear_sampler.sv -----
// Top level of the staggered grid trilinear sampler
//
// Input channel (in_valid / in_stall) takes write and sample requests.
// A write stores in_entry_value at (i, j, k) of one store in the cycle it is
// transferred; out-of-extent writes are dropped. A sample maps the position
// to grid coordinates, reads eight corners and blends them trilinearly.
// Result channel (out_valid / out_stall) gives one result per store sampled;
// velocity mode gives U, V then W, with out_is_last on the final one.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while idle; the block does not enforce this. A sample
// scales the three axes, then per store reads the eight corners and blends
// them, then presents the result. One 32x16 multiplier does all scaling
// and blending, and one store read port sets the corner fetch rate.
// in_stall is high from the transfer of a sample until the last result
// leaves, and while rst_n is low. A stalled result holds unchanged.
// Reset (rst_n low) returns to idle and restores the configuration
// defaults; store contents are kept.
`timescale 1ns / 1ps
`include "staggered_grid_trilinear_sampler_defines.svh"

module staggered_grid_trilinear_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_component,
  input  logic [5:0]  in_cell_i,
  input  logic [5:0]  in_cell_j,
  input  logic [5:0]  in_cell_k,
  input  logic [31:0] in_entry_value,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sample_value,
  output logic [1:0]  out_sample_component,
  output logic        out_is_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import sgts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LERP  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam int PW = 6 + FRAC_BITS;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic [2:0]  lcnt_r;
  logic [1:0]  ph_r;
  logic [2:0]  comp_r;
  logic [1:0]  cur_r;
  logic [31:0] org_r [3];
  logic [31:0] inv_r;
  logic [5:0]  cells_r [3];
  logic [31:0] ud_r [3];
  logic [PW-1:0] p_r [3];
  logic [31:0] lo_r;
  logic [47:0] mul_r;
  logic [32:0] diff_r;
  logic        neg_r;
  logic [31:0] q_r [8];

  logic [5:0]  n_eff [3];
  logic [6:0]  vi [3];
  logic [15:0] fr [3];
  logic [5:0]  ext_m1 [3];
  logic [5:0]  idx [3];
  logic [31:0] pos [3];
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [15:0] t_sel;
  logic        in_acc, last;
  logic [1:0]  ax;
  logic [48:0] sum;
  logic [PW-1:0] limit;
  logic [31:0] m_val, res;
  logic [31:0] rd_data;
  sgts_wr_t    wr;
  sgts_rd_t    rd;

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;
  assign last     = (comp_r != COMP_VEL) || (cur_r == STORE_W);
  assign pos[0]   = in_pos_x;
  assign pos[1]   = in_pos_y;
  assign pos[2]   = in_pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [PW:0] v;
      logic [7:0]  t;
      logic [7:0]  tm;
      n_eff[a]  = eff_cells(cells_r[a]);
      v         = (PW+1)'(p_r[a]) + (PW+1)'(1 << FRAC_BITS)
                  - ((2'(a) != cur_r) ? (PW+1)'(1 << (FRAC_BITS - 1)) : '0);
      vi[a]     = v[PW:FRAC_BITS];
      fr[a]     = v[FRAC_BITS-1:0];
      ext_m1[a] = n_eff[a] - 6'd1 + ((2'(a) == cur_r) ? 6'd1 : 6'd0);
      t         = 8'(vi[a]) + 8'(cnt_r[a]);
      tm        = t - 8'd1;
      if (t == 8'd0) idx[a] = 6'd0;
      else if (tm > 8'(ext_m1[a])) idx[a] = ext_m1[a];
      else idx[a] = tm[5:0];
    end
  end

  always_comb begin
    wr.sel  = in_component[1:0];
    wr.addr = grid_addr(in_component[1:0], in_cell_i, in_cell_j, in_cell_k);
    wr.data = in_entry_value;
    wr.we   = in_acc && (in_req_type == REQ_WRITE) && (in_component <= COMP_SCALAR)
              && (7'(in_cell_i) < 7'(n_eff[0]) + ((in_component[1:0] == STORE_U) ? 7'd1 : 7'd0))
              && (7'(in_cell_j) < 7'(n_eff[1]) + ((in_component[1:0] == STORE_V) ? 7'd1 : 7'd0))
              && (7'(in_cell_k) < 7'(n_eff[2]) + ((in_component[1:0] == STORE_W) ? 7'd1 : 7'd0));
    rd.re   = (state_r == S_READ) && (cnt_r < 4'd8);
    rd.sel  = cur_r;
    rd.addr = grid_addr(cur_r, idx[0], idx[1], idx[2]);
  end

  sgts_grid_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_comb begin
    if (lcnt_r < 3'd4) t_sel = fr[0];
    else if (lcnt_r < 3'd6) t_sel = fr[1];
    else t_sel = fr[2];
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SCALE && cnt_r < 4'd6) begin
      mul_a = ud_r[cnt_r[2:1]];
      mul_b = cnt_r[0] ? inv_r[31:16] : inv_r[15:0];
    end else if (state_r == S_LERP) begin
      mul_a = diff_r[32] ? 32'(-diff_r) : diff_r[31:0];
      mul_b = t_sel;
    end
    ax    = cnt_r[2:1] - 2'd1;
    sum   = 49'(mul_r) + 49'(lo_r);
    limit = {n_eff[ax], FRAC_BITS'(0)};
    m_val = mul_r[47:FRAC_BITS];
    res   = neg_r ? (q_r[0] - m_val) : (q_r[0] + m_val);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_req_type == REQ_SAMPLE && in_component <= COMP_VEL)
                 state_nxt = S_SCALE;
      S_SCALE: if (cnt_r == 4'd6) state_nxt = S_READ;
      S_READ:  if (cnt_r == 4'd8) state_nxt = S_LERP;
      S_LERP:  if (lcnt_r == 3'd6 && ph_r == 2'd2) state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = last ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      lcnt_r     <= '0;
      ph_r       <= '0;
      org_r[0]   <= '0;
      org_r[1]   <= '0;
      org_r[2]   <= '0;
      inv_r      <= 32'd65536;
      cells_r[0] <= 6'd32;
      cells_r[1] <= 6'd32;
      cells_r[2] <= 6'd32;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r  <= '0;
        lcnt_r <= '0;
        ph_r   <= '0;
      end else if (state_r == S_LERP) begin
        if (ph_r == 2'd2) begin
          ph_r   <= '0;
          lcnt_r <= lcnt_r + 3'd1;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end else begin
        cnt_r <= cnt_r + 4'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: org_r[0]   <= cfg_wdata;
          CFG_ORIGIN_Y: org_r[1]   <= cfg_wdata;
          CFG_ORIGIN_Z: org_r[2]   <= cfg_wdata;
          CFG_INV_CELL: inv_r      <= cfg_wdata;
          CFG_CELLS_X:  cells_r[0] <= cfg_wdata[5:0];
          CFG_CELLS_Y:  cells_r[1] <= cfg_wdata[5:0];
          CFG_CELLS_Z:  cells_r[2] <= cfg_wdata[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= 48'(mul_a) * 48'(mul_b);
    unique case (state_r)
      S_IDLE: begin
        comp_r <= in_component;
        cur_r  <= (in_component == COMP_VEL) ? STORE_U : in_component[1:0];
        for (int a = 0; a < 3; a++) begin
          logic [32:0] d;
          d = {pos[a][31], pos[a]} - {org_r[a][31], org_r[a]};
          ud_r[a] <= (d[32] || d == 33'd0) ? 32'd0 : d[31:0];
        end
      end
      S_SCALE: begin
        if (cnt_r[0]) lo_r <= mul_r[47:FRAC_BITS];
        else if (cnt_r != 4'd0) p_r[ax] <= (sum > 49'(limit)) ? limit : sum[PW-1:0];
      end
      S_READ: begin
        if (cnt_r != 4'd0) begin
          for (int i = 0; i < 7; i++) q_r[i] <= q_r[i+1];
          q_r[7] <= rd_data;
        end
      end
      S_LERP: begin
        if (ph_r == 2'd0) begin
          diff_r <= {q_r[1][31], q_r[1]} - {q_r[0][31], q_r[0]};
        end else if (ph_r == 2'd1) begin
          neg_r <= diff_r[32];
        end else begin
          for (int i = 0; i < 6; i++) q_r[i] <= (3'(i) == 3'd6 - lcnt_r) ? res : q_r[i+2];
          if (lcnt_r == 3'd0) q_r[6] <= res;
        end
      end
      S_OUT: begin
        if (!out_stall && !last) cur_r <= cur_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_valid            = (state_r == S_OUT);
  assign out_sample_value     = q_r[0];
  assign out_sample_component = cur_r;
  assign out_is_last          = last;

  `SGTS_ASSERT_NOW(a_no_accept_with_result, out_valid, in_stall, "input taken while result held")
  `SGTS_ASSERT_NOW(a_single_is_last, out_valid && comp_r != COMP_VEL, out_is_last,
                   "single-store sample not marked last")
  `SGTS_ASSERT_NEXT(a_gap_after_partial, out_valid && !out_stall && !out_is_last, !out_valid,
                    "velocity result repeated without refetch")
  `SGTS_ASSERT_NEXT(a_sample_starts,
                    in_valid && !in_stall && in_req_type == REQ_SAMPLE && in_component <= COMP_VEL,
                    state_r == S_SCALE, "sample request did not start scaling")

endmodule

// ----- test/staggered_grid_trilinear_sampler_tb.sv -----
// Testbench for the staggered grid trilinear sampler: store writes, samples and register settings
`timescale 1ns / 1ps

module staggered_grid_trilinear_sampler_tb;
  import sgts_pkg::*;

  localparam logic [2:0] COMP_V = {1'b0, STORE_V};
  localparam logic [2:0] COMP_W = {1'b0, STORE_W};
  localparam int FILL_CELLS = 2;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  store;
    logic        last;
  } grid_result_t;

  class grid_scoreboard;
    logic [31:0] grid[4][FACE_DEPTH];
    logic [31:0] org[3];
    logic [31:0] inv_h;
    logic [5:0]  cells[3];
    grid_result_t pending[$];
    int errors;
    int results;
    int samples;

    function new();
      inv_h = 32'd65536;
      foreach (org[a]) org[a] = '0;
      foreach (cells[a]) cells[a] = 6'd32;
      errors = 0;
      results = 0;
      samples = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_ORIGIN_X: org[0] = val;
        CFG_ORIGIN_Y: org[1] = val;
        CFG_ORIGIN_Z: org[2] = val;
        CFG_INV_CELL: inv_h = val;
        CFG_CELLS_X:  cells[0] = val[5:0];
        CFG_CELLS_Y:  cells[1] = val[5:0];
        CFG_CELLS_Z:  cells[2] = val[5:0];
        default: ;
      endcase
    endfunction

    function int span(int a);
      if (cells[a] == 0) return 1;
      if (cells[a] > MAX_CELLS) return MAX_CELLS;
      return cells[a];
    endfunction

    function int slot(int s, int i, int j, int k);
      int ex, ey;
      ex = (s == 0) ? MAX_CELLS + 1 : MAX_CELLS;
      ey = (s == 1) ? MAX_CELLS + 1 : MAX_CELLS;
      return (k * ey + j) * ex + i;
    endfunction

    function longint unsigned scale(logic [31:0] pos, logic [31:0] o, int n);
      longint d;
      longint unsigned lim, ud, a, full, p;
      d = longint'($signed(pos)) - longint'($signed(o));
      lim = longint'(n) << FRAC_BITS;
      if (d <= 0) return 0;
      ud = d;
      a = ud * (inv_h >> 16);
      if (a >= (64'd1 << 47)) return lim;
      full = (a << 16) + ud * inv_h[15:0];
      p = full >> FRAC_BITS;
      return (p > lim) ? lim : p;
    endfunction

    function longint blend(longint a, longint b, longint unsigned t);
      longint d;
      longint unsigned m;
      d = b - a;
      m = (d < 0) ? -d : d;
      m = (m * t) >> FRAC_BITS;
      return (d < 0) ? a - longint'(m) : a + longint'(m);
    endfunction

    function logic [31:0] interp(int s, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint unsigned q[3], fr[3], v;
      longint base[3], ext[3], c[8], x[3];
      q[0] = scale(px, org[0], span(0));
      q[1] = scale(py, org[1], span(1));
      q[2] = scale(pz, org[2], span(2));
      for (int a = 0; a < 3; a++) begin
        v = q[a] + (64'd1 << FRAC_BITS);
        if (a != s) v -= 64'd1 << (FRAC_BITS - 1);
        base[a] = longint'(v >> FRAC_BITS) - 1;
        fr[a] = v & 64'hFFFF;
        ext[a] = span(a) + ((a == s) ? 1 : 0);
      end
      for (int n = 0; n < 8; n++) begin
        for (int a = 0; a < 3; a++) begin
          x[a] = base[a] + ((n >> a) & 1);
          if (x[a] < 0) x[a] = 0;
          if (x[a] > ext[a] - 1) x[a] = ext[a] - 1;
        end
        c[n] = longint'($signed(grid[s][slot(s, x[0], x[1], x[2])]));
      end
      return 32'(blend(blend(blend(c[0], c[1], fr[0]), blend(c[2], c[3], fr[0]), fr[1]),
                       blend(blend(c[4], c[5], fr[0]), blend(c[6], c[7], fr[0]), fr[1]),
                       fr[2]));
    endfunction

    function void note(logic rt, logic [2:0] comp, logic [5:0] i, logic [5:0] j,
                       logic [5:0] k, logic [31:0] val, logic [31:0] px,
                       logic [31:0] py, logic [31:0] pz);
      grid_result_t r;
      if (rt == REQ_WRITE) begin
        if (comp > COMP_SCALAR) return;
        if (i >= span(0) + (comp == COMP_U) || j >= span(1) + (comp == COMP_V) ||
            k >= span(2) + (comp == COMP_W)) return;
        grid[comp][slot(comp, i, j, k)] = val;
      end else if (comp <= COMP_SCALAR) begin
        r.value = interp(comp, px, py, pz);
        r.store = comp[1:0];
        r.last = 1'b1;
        pending.push_back(r);
        samples++;
      end else if (comp == COMP_VEL) begin
        for (int s = 0; s < 3; s++) begin
          r.value = interp(s, px, py, pz);
          r.store = s[1:0];
          r.last = (s == 2);
          pending.push_back(r);
        end
        samples++;
      end
    endfunction

    function void check(logic [31:0] val, logic [1:0] st, logic last);
      grid_result_t r;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result value %h store %0d", val, st);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (val !== r.value) begin
        $error("sample_value expected %h actual %h", r.value, val);
        errors++;
      end
      if (st !== r.store) begin
        $error("sample_component expected %0d actual %0d", r.store, st);
        errors++;
      end
      if (last !== r.last) begin
        $error("is_last expected %0b actual %0b", r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_req_type;
  logic [2:0] in_component;
  logic [5:0] in_cell_i, in_cell_j, in_cell_k;
  logic [31:0] in_entry_value, in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, out_stall, out_is_last;
  logic [31:0] out_sample_value;
  logic [1:0] out_sample_component;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  grid_scoreboard sb = new();
  bit quiet;
  bit gaps;
  int stall_left;

  staggered_grid_trilinear_sampler DUT (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check(out_sample_value, out_sample_component, out_is_last);
  end

  task automatic transfer(logic rt, logic [2:0] comp, logic [5:0] i, logic [5:0] j,
                          logic [5:0] k, logic [31:0] val, logic [31:0] px,
                          logic [31:0] py, logic [31:0] pz);
    @(negedge clk);
    if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = rt;
    in_component = comp;
    in_cell_i = i;
    in_cell_j = j;
    in_cell_k = k;
    in_entry_value = val;
    in_pos_x = px;
    in_pos_y = py;
    in_pos_z = pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(rt, comp, i, j, k, val, px, py, pz);
  endtask

  task automatic put(logic [2:0] comp, logic [5:0] i, logic [5:0] j, logic [5:0] k,
                     logic [31:0] val);
    transfer(REQ_WRITE, comp, i, j, k, val, $urandom, $urandom, $urandom);
  endtask

  task automatic probe(logic [2:0] comp, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    transfer(REQ_SAMPLE, comp, $urandom, $urandom, $urandom, $urandom, px, py, pz);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic setup(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [31:0] ih,
                       logic [5:0] nx, logic [5:0] ny, logic [5:0] nz);
    settle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_CELL, ih);
    write_reg(CFG_CELLS_X, {26'd0, nx});
    write_reg(CFG_CELLS_Y, {26'd0, ny});
    write_reg(CFG_CELLS_Z, {26'd0, nz});
  endtask

  function automatic logic [31:0] near_pos(int a);
    longint unsigned w;
    w = ((longint'(sb.span(a)) + 1) << 32) / sb.inv_h;
    if (w == 0) w = 1;
    if (w > 64'hFFFFFFFF) w = 64'hFFFFFFFF;
    return sb.org[a] + 32'({$urandom, $urandom} % w) - 32'($urandom_range(0, 3));
  endfunction

  task automatic random_items(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      if (n == count - 25) quiet = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 8) begin
        put($urandom_range(0, 3), $urandom_range(0, 33), $urandom_range(0, 33),
            $urandom_range(0, 33), $urandom);
      end else if (r == 8) begin
        transfer($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      end else if (r < 11) begin
        probe($urandom_range(0, 7), $urandom, $urandom, $urandom);
      end else begin
        probe($urandom_range(0, 4), near_pos(0), near_pos(1), near_pos(2));
      end
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_req_type = REQ_WRITE;
    in_component = COMP_U;
    {in_cell_i, in_cell_j, in_cell_k} = '0;
    {in_entry_value, in_pos_x, in_pos_y, in_pos_z} = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_wdata = '0;
    quiet = 1'b0;
    gaps = 1'b0;
    stall_left = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill the low corner of each store; the small grids below read nothing else
    for (int s = 0; s < 4; s++)
      for (int k = 0; k < FILL_CELLS + (s == 2); k++)
        for (int j = 0; j < FILL_CELLS + (s == 1); j++)
          for (int i = 0; i < FILL_CELLS + (s == 0); i++)
            put(s, i, j, k, $urandom);
    gaps = 1'b1;

    put(COMP_U, 0, 0, 0, 32'h7FFFFFFF);
    put(COMP_U, 1, 0, 0, 32'h80000000);
    put(COMP_V, 32, 33, 0, 32'h12345678);
    put(COMP_W, 63, 63, 63, 32'hFFFFFFFF);
    put(3'd7, 1, 1, 1, 32'hDEADBEEF);
    put(COMP_SCALAR, 31, 31, 31, 32'h00010000);
    probe(COMP_U, 32'h00008000, 32'h00004000, 32'h0);
    probe(COMP_V, 32'h80000000, 32'h80000000, 32'h80000000);
    probe(COMP_VEL, 32'h00008000, 32'h00008000, 32'h00008000);
    probe(3'd5, 32'h00010000, 32'h00010000, 32'h00010000);
    probe(3'd7, 32'h0, 32'h0, 32'h0);

    setup(32'h0, 32'h0, 32'h0, 32'd65536, 6'd2, 6'd2, 6'd2);
    probe(COMP_W, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    probe(COMP_SCALAR, 32'h001F8000, 32'h001F8000, 32'h001F8000);
    probe(COMP_VEL, 32'h00018000, 32'h00020000, 32'h0002C000);
    random_items(40);

    quiet = 1'b0;
    setup(32'hFFFF0000, 32'h00020000, 32'h80000000, 32'd131072, 6'd1, 6'd0, 6'd2);
    put(COMP_U, 1, 0, 0, 32'h00050000);
    put(COMP_U, 2, 0, 0, 32'h00090000);
    put(COMP_V, 0, 2, 0, 32'h00070000);
    probe(COMP_VEL, 32'h7FFFFFFF, 32'h00000000, 32'h00000000);
    random_items(30);

    quiet = 1'b0;
    setup(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 6'd2, 6'd1, 6'd2);
    random_items(30);

    quiet = 1'b0;
    setup(32'h0, 32'h0, 32'h0, 32'd1, 6'd0, 6'd2, 6'd1);
    random_items(20);

    quiet = 1'b0;
    setup($urandom, $urandom, $urandom, $urandom_range(16384, 400000), 6'd2, 6'd1, 6'd2);
    random_items(30);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("covered store writes, %0d sample requests and %0d results", sb.samples,
             sb.results);
    $display("across five register settings including origin, scale and cell count extremes");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule
